// File: design/opu_pkg.sv
// ----------------------------------------------------------------------------
// opu_pkg
// shared types and constants for the optimizer parameter update block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package opu_pkg;

  // value format, signed or unsigned q8.24
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned FRAC_W  = 24;
  // coefficient format, unsigned q0.24
  localparam int unsigned COEF_W  = 24;
  // batch count and step number
  localparam int unsigned CNT_W   = 16;

  // shared divide / square root unit
  localparam int unsigned DSU_X_W    = 56;  // dividend, radicand, quotient
  localparam int unsigned DSU_D_W    = 29;  // divisor and partial remainder
  localparam int unsigned DSU_ROOT_W = 28;  // square root result
  localparam int unsigned DSU_CNT_W  = 6;

  localparam logic [DSU_CNT_W-1:0] DIV_SHORT  = 6'd32;
  localparam logic [DSU_CNT_W-1:0] DIV_LONG   = 6'd56;
  localparam logic [DSU_CNT_W-1:0] SQRT_STEPS = 6'd28;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 3'd7;

  // update modes
  localparam logic MODE_SGD   = 1'b0;
  localparam logic MODE_ADAMW = 1'b1;

  typedef enum logic {
    DSU_DIV  = 1'b0,
    DSU_SQRT = 1'b1
  } dsu_op_e;

  typedef struct packed {
    logic                 start;
    dsu_op_e              op;
    logic [DSU_CNT_W-1:0] iters;
  } dsu_req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] gradient_sum;
    logic signed [VALUE_W-1:0] weight_in;
    logic signed [VALUE_W-1:0] moment_one_in;
    logic        [VALUE_W-1:0] moment_two_in;
    logic                      last_element;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] weight_out;
    logic signed [VALUE_W-1:0] moment_one_out;
    logic        [VALUE_W-1:0] moment_two_out;
    logic                      last_out;
  } out_item_t;

endpackage

`default_nettype wire

// File: design/optimizer_parameter_update.sv
// ----------------------------------------------------------------------------
// optimizer_parameter_update
// adamw / gradient descent update of one q8.24 parameter and its moments
// per item, on one shared multiplier and one shared divide/sqrt unit
// ----------------------------------------------------------------------------
//
// channel  dir  handshake                  payload
// in       in   in_valid_i / in_stall_o    opu_pkg::in_item_t
// out      out  out_valid_o / out_stall_i  opu_pkg::out_item_t
// cfg      in   cfg_we_i, no wait          cfg_idx_i, cfg_data_i
//
// one item is taken at a time; the input stalls until its result is loaded;
// the divide/sqrt unit retires one bit per cycle and is used up to five
// times in adamw mode (gradient average, two bias corrections, root,
// quotient unless the denominator is zero), once in gradient descent
// the first item of a run first computes the two beta powers
// (sixteen squarings per power plus one product per set bit of step_number)
// reset is asynchronous, active low; it loads the register defaults
// a held result in the output register does not block the next item,
// only the final load of the following result waits for it
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module optimizer_parameter_update (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  opu_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output opu_pkg::out_item_t            out_item_o,
  input  logic                          cfg_we_i,
  input  logic [opu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [opu_pkg::COEF_W-1:0]    cfg_data_i
);
  import opu_pkg::*;

  // sequencer, one state per step of the update
  typedef enum logic [21:0] {
    ST_IDLE    = 22'h000001,
    ST_PW_SQ   = 22'h000002,
    ST_PW_MUL  = 22'h000004,
    ST_BRANCH  = 22'h000008,
    ST_M0_MUL  = 22'h000010,
    ST_M0_WAIT = 22'h000020,
    ST_G_WAIT  = 22'h000040,
    ST_GG      = 22'h000080,
    ST_M1A     = 22'h000100,
    ST_M1B     = 22'h000200,
    ST_M1C     = 22'h000400,
    ST_V1      = 22'h000800,
    ST_V2      = 22'h001000,
    ST_V3      = 22'h002000,
    ST_V4      = 22'h004000,
    ST_MH_WAIT = 22'h008000,
    ST_VH_WAIT = 22'h010000,
    ST_SQ_WAIT = 22'h020000,
    ST_Q_WAIT  = 22'h040000,
    ST_W1      = 22'h080000,
    ST_W2      = 22'h100000,
    ST_OUT     = 22'h200000
  } state_e;

  localparam logic [COEF_W:0] COEF_ONE = 25'h100_0000;
  localparam int unsigned     G2_W     = 2 * VALUE_W - FRAC_W - 1;

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------
  function automatic logic [VALUE_W-1:0] mag_of(input logic [VALUE_W-1:0] x);
    return x[VALUE_W-1] ? (~x + 1'b1) : x;
  endfunction

  // clamp a magnitude to the signed range for the given sign
  function automatic logic [VALUE_W-1:0] sat_mag(input logic neg,
                                                 input logic [DSU_X_W-1:0] mag);
    logic [DSU_X_W-1:0] lim;
    lim = {{(DSU_X_W-VALUE_W){1'b0}}, neg, {(VALUE_W-1){~neg}}};
    return (mag > lim) ? lim[VALUE_W-1:0] : mag[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] sat36(input logic signed [35:0] x);
    if (x[35:31] == {5{x[35]}}) begin
      return x[VALUE_W-1:0];
    end
    return x[35] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic              mode_q;
  logic [COEF_W-1:0] lr_q, b1_q, b2_q, eps_q, decay_q;
  logic [CNT_W-1:0]  bc_q, sn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ADAMW;
      lr_q    <= 24'd16777;
      b1_q    <= 24'd15099494;
      b2_q    <= 24'd16760438;
      eps_q   <= 24'd1;
      decay_q <= 24'd168;
      bc_q    <= 16'd1;
      sn_q    <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:  mode_q  <= cfg_data_i[0];
        CFG_LR:    lr_q    <= cfg_data_i;
        CFG_B1:    b1_q    <= cfg_data_i;
        CFG_B2:    b2_q    <= cfg_data_i;
        CFG_EPS:   eps_q   <= cfg_data_i;
        CFG_DECAY: decay_q <= cfg_data_i;
        CFG_BATCH: bc_q    <= cfg_data_i[CNT_W-1:0];
        CFG_STEP:  sn_q    <= cfg_data_i[CNT_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  in_item_t            in_q, in_d;
  logic                run_start_q, run_start_d;
  logic [COEF_W-1:0]   p1_q, p1_d, p2_q, p2_d;      // beta powers
  logic [COEF_W:0]     r_q, r_d;                    // power accumulator
  logic [3:0]          pw_bit_q, pw_bit_d;
  logic                sel_q, sel_d;                // 0 beta one, 1 beta two
  logic [VALUE_W-1:0]  g_mag_q, g_mag_d;            // |gradient / batch|
  logic [G2_W-1:0]     g2_q, g2_d;                  // g*g >> frac
  logic signed [63:0]  acc_q, acc_d;
  logic [VALUE_W-1:0]  m_q, m_d, v_q, v_d;
  logic [VALUE_W-1:0]  mhat_mag_q, mhat_mag_d;
  logic [VALUE_W-1:0]  q_mag_q, q_mag_d;
  logic signed [32:0]  t1_q, t1_d;                  // learning rate term
  logic [VALUE_W-1:0]  wn_q, wn_d;
  out_item_t           out_q, out_d;
  logic                out_vld_q, out_vld_d;

  // shared multiplier
  logic [VALUE_W-1:0]  mul_a, mul_b;
  logic                mul_neg;
  logic [63:0]         prod;
  logic signed [63:0]  sprod;

  // shared divide / sqrt unit
  dsu_req_t            dsu_req;
  logic [DSU_X_W-1:0]  dsu_dividend;
  logic [DSU_D_W-1:0]  dsu_divisor;
  logic                dsu_done;
  logic [DSU_X_W-1:0]  dsu_res;

  // derived values
  logic [CNT_W-1:0]    b_eff, t_eff;
  logic                gs_neg, w_neg, m_in_neg;
  logic [VALUE_W-1:0]  gs_mag, w_mag, m_in_mag;
  logic [63:0]         acc_mag;
  logic [VALUE_W-1:0]  m_sat_mag;
  logic [VALUE_W-1:0]  v_new, vhat;
  logic [DSU_D_W-1:0]  den;
  logic [COEF_W-1:0]   beta_cur;
  logic [COEF_W:0]     om_b1, om_b2, div_p1, div_p2;
  logic signed [35:0]  w_ext;
  logic signed [35:0]  d_ext;
  logic signed [32:0]  t2;
  logic signed [35:0]  t_sum;

  assign prod  = 64'(mul_a) * 64'(mul_b);
  assign sprod = mul_neg ? -$signed(prod) : $signed(prod);

  assign b_eff    = (bc_q == '0) ? CNT_W'(1) : bc_q;
  assign t_eff    = (sn_q == '0) ? CNT_W'(1) : sn_q;
  assign gs_neg   = in_q.gradient_sum[VALUE_W-1];
  assign w_neg    = in_q.weight_in[VALUE_W-1];
  assign m_in_neg = in_q.moment_one_in[VALUE_W-1];
  assign gs_mag   = mag_of(in_q.gradient_sum);
  assign w_mag    = mag_of(in_q.weight_in);
  assign m_in_mag = mag_of(in_q.moment_one_in);

  // truncating divide of the accumulator by one in q0.24
  assign acc_mag   = acc_q[63] ? (~acc_q + 64'd1) : acc_q;
  assign m_sat_mag = sat_mag(acc_q[63], {16'b0, acc_mag[63:FRAC_W]});
  assign v_new     = (acc_q[63:56] != '0) ? '1 : acc_q[55:FRAC_W];
  assign vhat      = (dsu_res[DSU_X_W-1:VALUE_W] != '0) ? '1 : dsu_res[VALUE_W-1:0];
  assign den       = {1'b0, dsu_res[DSU_ROOT_W-1:0]} + {5'b0, eps_q};

  assign beta_cur = sel_q ? b2_q : b1_q;
  assign om_b1    = COEF_ONE - {1'b0, b1_q};
  assign om_b2    = COEF_ONE - {1'b0, b2_q};
  assign div_p1   = COEF_ONE - {1'b0, p1_q};
  assign div_p2   = COEF_ONE - {1'b0, p2_q};

  assign w_ext = 36'($signed(in_q.weight_in));
  assign d_ext = $signed({4'b0, dsu_res[VALUE_W-1:0]});
  assign t2    = w_neg ? -$signed({1'b0, prod[55:FRAC_W]})
                       : $signed({1'b0, prod[55:FRAC_W]});
  assign t_sum = 36'(t1_q) + 36'(t2);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    in_d        = in_q;
    run_start_d = run_start_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    r_d         = r_q;
    pw_bit_d    = pw_bit_q;
    sel_d       = sel_q;
    g_mag_d     = g_mag_q;
    g2_d        = g2_q;
    acc_d       = acc_q;
    m_d         = m_q;
    v_d         = v_q;
    mhat_mag_d  = mhat_mag_q;
    q_mag_d     = q_mag_q;
    t1_d        = t1_q;
    wn_d        = wn_q;
    out_d       = out_q;
    out_vld_d   = out_vld_q;

    mul_a        = '0;
    mul_b        = '0;
    mul_neg      = 1'b0;
    dsu_req      = '{start: 1'b0, op: DSU_DIV, iters: DIV_SHORT};
    dsu_dividend = '0;
    dsu_divisor  = '0;

    // downstream took the held result
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_d        = in_item_i;
          // powers are refreshed on the first item of a run
          run_start_d = in_item_i.last_element;
          if (run_start_q) begin
            sel_d    = 1'b0;
            pw_bit_d = 4'd15;
            r_d      = COEF_ONE;
            state_d  = ST_PW_SQ;
          end else begin
            state_d = ST_BRANCH;
          end
        end
      end

      // square and multiply, msb of the step number first
      ST_PW_SQ, ST_PW_MUL: begin
        mul_a = VALUE_W'(r_q);
        mul_b = (state_q == ST_PW_SQ) ? VALUE_W'(r_q) : VALUE_W'(beta_cur);
        r_d   = prod[2*COEF_W:COEF_W];
        if (state_q == ST_PW_SQ && t_eff[pw_bit_q]) begin
          state_d = ST_PW_MUL;
        end else if (pw_bit_q != '0) begin
          pw_bit_d = pw_bit_q - 1'b1;
          state_d  = ST_PW_SQ;
        end else if (!sel_q) begin
          p1_d     = prod[2*COEF_W-1:COEF_W];
          sel_d    = 1'b1;
          pw_bit_d = 4'd15;
          r_d      = COEF_ONE;
          state_d  = ST_PW_SQ;
        end else begin
          p2_d    = prod[2*COEF_W-1:COEF_W];
          state_d = ST_BRANCH;
        end
      end

      ST_BRANCH: begin
        if (mode_q == MODE_SGD) begin
          state_d = ST_M0_MUL;
        end else begin
          // g = gradient / batch
          dsu_req      = '{start: 1'b1, op: DSU_DIV, iters: DIV_SHORT};
          dsu_dividend = {gs_mag, {FRAC_W{1'b0}}};
          dsu_divisor  = DSU_D_W'(b_eff);
          state_d      = ST_G_WAIT;
        end
      end

      // gradient descent: (lr*|G| >> 24) / batch
      ST_M0_MUL: begin
        mul_a        = VALUE_W'(lr_q);
        mul_b        = gs_mag;
        dsu_req      = '{start: 1'b1, op: DSU_DIV, iters: DIV_SHORT};
        dsu_dividend = {prod[55:FRAC_W], {FRAC_W{1'b0}}};
        dsu_divisor  = DSU_D_W'(b_eff);
        state_d      = ST_M0_WAIT;
      end

      ST_M0_WAIT: begin
        if (dsu_done) begin
          wn_d    = sat36(gs_neg ? (w_ext + d_ext) : (w_ext - d_ext));
          state_d = ST_OUT;
        end
      end

      ST_G_WAIT: begin
        if (dsu_done) begin
          g_mag_d = dsu_res[VALUE_W-1:0];
          state_d = ST_GG;
        end
      end

      ST_GG: begin
        mul_a   = g_mag_q;
        mul_b   = g_mag_q;
        g2_d    = prod[2*VALUE_W-2:FRAC_W];
        state_d = ST_M1A;
      end

      // first moment: b1*m + (1-b1)*g
      ST_M1A: begin
        mul_a   = VALUE_W'(b1_q);
        mul_b   = m_in_mag;
        mul_neg = m_in_neg;
        acc_d   = sprod;
        state_d = ST_M1B;
      end

      ST_M1B: begin
        mul_a   = VALUE_W'(om_b1);
        mul_b   = g_mag_q;
        mul_neg = gs_neg;
        acc_d   = acc_q + sprod;
        state_d = ST_M1C;
      end

      ST_M1C: begin
        m_d     = acc_q[63] ? (~m_sat_mag + 1'b1) : m_sat_mag;
        state_d = ST_V1;
      end

      // second moment: b2*v + (1-b2)*g2, g2 split at bit 32
      ST_V1: begin
        mul_a   = VALUE_W'(b2_q);
        mul_b   = in_q.moment_two_in;
        acc_d   = $signed(prod);
        state_d = ST_V2;
      end

      ST_V2: begin
        mul_a   = VALUE_W'(om_b2);
        mul_b   = g2_q[VALUE_W-1:0];
        acc_d   = acc_q + $signed(prod);
        state_d = ST_V3;
      end

      ST_V3: begin
        mul_a   = VALUE_W'(om_b2);
        mul_b   = VALUE_W'(g2_q[G2_W-1:VALUE_W]);
        acc_d   = acc_q + $signed({prod[VALUE_W-1:0], {VALUE_W{1'b0}}});
        state_d = ST_V4;
      end

      // bias correction of m
      ST_V4: begin
        v_d          = v_new;
        dsu_req      = '{start: 1'b1, op: DSU_DIV, iters: DIV_LONG};
        dsu_dividend = {mag_of(m_q), {FRAC_W{1'b0}}};
        dsu_divisor  = DSU_D_W'(div_p1);
        state_d      = ST_MH_WAIT;
      end

      // bias correction of v
      ST_MH_WAIT: begin
        if (dsu_done) begin
          mhat_mag_d   = sat_mag(m_q[VALUE_W-1], dsu_res);
          dsu_req      = '{start: 1'b1, op: DSU_DIV, iters: DIV_LONG};
          dsu_dividend = {v_q, {FRAC_W{1'b0}}};
          dsu_divisor  = DSU_D_W'(div_p2);
          state_d      = ST_VH_WAIT;
        end
      end

      ST_VH_WAIT: begin
        if (dsu_done) begin
          dsu_req      = '{start: 1'b1, op: DSU_SQRT, iters: SQRT_STEPS};
          dsu_dividend = {vhat, {FRAC_W{1'b0}}};
          state_d      = ST_SQ_WAIT;
        end
      end

      // mhat / (sqrt(vhat) + eps); a zero denominator saturates by sign
      ST_SQ_WAIT: begin
        if (dsu_done) begin
          if (den == '0) begin
            q_mag_d = (mhat_mag_q == '0) ? '0 : sat_mag(m_q[VALUE_W-1], '1);
            state_d = ST_W1;
          end else begin
            dsu_req      = '{start: 1'b1, op: DSU_DIV, iters: DIV_LONG};
            dsu_dividend = {mhat_mag_q, {FRAC_W{1'b0}}};
            dsu_divisor  = den;
            state_d      = ST_Q_WAIT;
          end
        end
      end

      ST_Q_WAIT: begin
        if (dsu_done) begin
          q_mag_d = sat_mag(m_q[VALUE_W-1], dsu_res);
          state_d = ST_W1;
        end
      end

      ST_W1: begin
        mul_a   = VALUE_W'(lr_q);
        mul_b   = q_mag_q;
        t1_d    = m_q[VALUE_W-1] ? -$signed({1'b0, prod[55:FRAC_W]})
                                 : $signed({1'b0, prod[55:FRAC_W]});
        state_d = ST_W2;
      end

      // decay term is not scaled by the learning rate
      ST_W2: begin
        mul_a   = VALUE_W'(decay_q);
        mul_b   = w_mag;
        wn_d    = sat36(w_ext - t_sum);
        state_d = ST_OUT;
      end

      ST_OUT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_d.weight_out     = wn_q;
          out_d.moment_one_out = (mode_q == MODE_SGD) ? in_q.moment_one_in : m_q;
          out_d.moment_two_out = (mode_q == MODE_SGD) ? in_q.moment_two_in : v_q;
          out_d.last_out       = in_q.last_element;
          out_vld_d            = 1'b1;
          state_d              = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      run_start_q <= 1'b1;
      p1_q        <= '0;
      p2_q        <= '0;
      pw_bit_q    <= '0;
      sel_q       <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      run_start_q <= run_start_d;
      p1_q        <= p1_d;
      p2_q        <= p2_d;
      pw_bit_q    <= pw_bit_d;
      sel_q       <= sel_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q       <= in_d;
    r_q        <= r_d;
    g_mag_q    <= g_mag_d;
    g2_q       <= g2_d;
    acc_q      <= acc_d;
    m_q        <= m_d;
    v_q        <= v_d;
    mhat_mag_q <= mhat_mag_d;
    q_mag_q    <= q_mag_d;
    t1_q       <= t1_d;
    wn_q       <= wn_d;
    out_q      <= out_d;
  end

  // ---------------------------------------------------------------------------
  // shared divide / sqrt unit
  // ---------------------------------------------------------------------------
  opu_divsqrt u_divsqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (dsu_req),
    .dividend_i (dsu_dividend),
    .divisor_i  (dsu_divisor),
    .done_o     (dsu_done),
    .result_o   (dsu_res)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: design/opu_divsqrt.sv
// ----------------------------------------------------------------------------
// opu_divsqrt
// restoring divider and square root sharing one compare and subtract,
// one quotient bit or one root bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opu_divsqrt (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  opu_pkg::dsu_req_t               req_i,
  input  logic [opu_pkg::DSU_X_W-1:0]     dividend_i,
  input  logic [opu_pkg::DSU_D_W-1:0]     divisor_i,
  output logic                            done_o,
  output logic [opu_pkg::DSU_X_W-1:0]     result_o
);
  import opu_pkg::*;

  localparam int unsigned TRIAL_W = DSU_D_W + 2;

  logic                  busy_q;
  logic                  done_q;
  dsu_op_e               op_q;
  logic [DSU_CNT_W-1:0]  cnt_q;
  logic [DSU_X_W-1:0]    x_q;
  logic [DSU_D_W-1:0]    rem_q;
  logic [DSU_ROOT_W-1:0] root_q;
  logic [DSU_D_W-1:0]    divisor_q;

  logic [TRIAL_W-1:0]    trial;
  logic [TRIAL_W-1:0]    sub_op;
  logic [TRIAL_W:0]      diff;
  logic                  ge;
  logic [DSU_D_W-1:0]    rem_nx;

  // one trial subtraction per cycle
  always_comb begin
    unique case (op_q)
      DSU_SQRT: begin
        trial  = {rem_q, x_q[DSU_X_W-1 -: 2]};
        sub_op = {1'b0, root_q, 2'b01};
      end
      DSU_DIV: begin
        trial  = {1'b0, rem_q, x_q[DSU_X_W-1]};
        sub_op = {2'b00, divisor_q};
      end
    endcase
    diff   = {1'b0, trial} - {1'b0, sub_op};
    ge     = ~diff[TRIAL_W];
    rem_nx = ge ? diff[DSU_D_W-1:0] : trial[DSU_D_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= DSU_DIV;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DSU_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= req_i.iters;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= rem_nx;
      if (op_q == DSU_SQRT) begin
        x_q    <= {x_q[DSU_X_W-3:0], 2'b00};
        root_q <= {root_q[DSU_ROOT_W-2:0], ge};
      end else begin
        x_q <= {x_q[DSU_X_W-2:0], ge};
      end
    end else if (req_i.start) begin
      x_q       <= dividend_i;
      divisor_q <= divisor_i;
      rem_q     <= '0;
      root_q    <= '0;
    end
  end

  assign done_o   = done_q;
  assign result_o = (op_q == DSU_SQRT) ? DSU_X_W'(root_q) : x_q;

endmodule

`default_nettype wire

// File: dv/optimizer_parameter_update_tb.sv
// ----------------------------------------------------------------------------
// optimizer_parameter_update_tb
// self-checking bench: a directed table of items and register writes, then
// random phases of register settings and items, every result is compared
// against an in-bench adamw / gradient descent model, or against the typed-in
// value of a directed row, under random idling
`timescale 1ns / 1ps
`default_nettype none

module optimizer_parameter_update_tb;
  import opu_pkg::*;

  localparam longint CONE     = 64'sd16777216;  // 1.0 in q0.24 and q8.24
  localparam longint VAL_MAX  = 64'sd2147483647;
  localparam longint VAL_MIN  = -64'sd2147483648;
  localparam longint UVAL_MAX = 64'sd4294967295;
  localparam int     N_ITEMS  = 1850;
  localparam int     IDLE_LIMIT = 20000;  // cycles with no item moving
  localparam int     SETTLE   = 400;      // worst item plus beta powers

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_MODE;
  logic [COEF_W-1:0] cfg_data = '0;

  always #6 clk = ~clk;

  optimizer_parameter_update u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // shadow copy of the registers and the per-run state
  longint mode_r, lr_r, b1_r, b2_r, eps_r, decay_r, batch_r, step_r;
  longint b1_pow, b2_pow;
  bit run_fresh;

  out_item_t updates_due[$];
  int mismatches = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  int sent = 0;
  int sgd_items = 0;
  int adamw_items = 0;
  int zero_den_items = 0;

  function automatic longint sat_signed(longint x);
    if (x > VAL_MAX) return VAL_MAX;
    if (x < VAL_MIN) return VAL_MIN;
    return x;
  endfunction

  function automatic longint sat_unsigned(longint x);
    return (x > UVAL_MAX) ? UVAL_MAX : x;
  endfunction

  // beta^t, square-and-multiply from the top bit of t, truncated each step
  function automatic longint beta_to_step(longint beta, longint t);
    longint r;
    r = CONE;
    if (t == 0) t = 1;
    for (int i = 15; i >= 0; i--) begin
      r = (r * r) >>> 24;
      if (t[i]) r = (r * beta) >>> 24;
    end
    return r & (CONE - 1);
  endfunction

  function automatic longint floor_sqrt(longint x);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > x) b = b >>> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic void shadow_reset();
    mode_r = MODE_ADAMW; lr_r = 16777; b1_r = 15099494; b2_r = 16760438;
    eps_r = 1; decay_r = 168; batch_r = 1; step_r = 1;
    b1_pow = 0; b2_pow = 0; run_fresh = 1'b1;
  endfunction

  // updated parameter and moments for one item; advances the run state
  function automatic out_item_t update_param(in_item_t it);
    longint gs, w, m, v, b, wn, g, g2, mhat, vhat, den, q;
    out_item_t o;
    gs = longint'(it.gradient_sum);
    w  = longint'(it.weight_in);
    m  = longint'(it.moment_one_in);
    v  = longint'(it.moment_two_in);
    b  = (batch_r == 0) ? 1 : batch_r;
    if (run_fresh) begin
      b1_pow = beta_to_step(b1_r, step_r);
      b2_pow = beta_to_step(b2_r, step_r);
      run_fresh = 1'b0;
    end
    if (mode_r == MODE_SGD) begin
      wn = sat_signed(w - (lr_r * gs) / (b * CONE));
    end else begin
      g  = gs / b;
      g2 = (g * g) >>> 24;
      m  = sat_signed((b1_r * m + (CONE - b1_r) * g) / CONE);
      v  = sat_unsigned((b2_r * v + (CONE - b2_r) * g2) >>> 24);
      mhat = sat_signed(m * CONE / (CONE - b1_pow));
      vhat = sat_unsigned((v <<< 24) / (CONE - b2_pow));
      den  = floor_sqrt(vhat <<< 24) + eps_r;
      if (den == 0) begin
        // no denominator: quotient pinned by the sign of mhat
        q = (mhat > 0) ? VAL_MAX : ((mhat < 0) ? VAL_MIN : 0);
      end else begin
        q = sat_signed(mhat * CONE / den);
      end
      wn = sat_signed(w - ((lr_r * q) / CONE + (decay_r * w) / CONE));
    end
    o.weight_out     = wn[31:0];
    o.moment_one_out = m[31:0];
    o.moment_two_out = v[31:0];
    o.last_out       = it.last_element;
    if (it.last_element) run_fresh = 1'b1;
    return o;
  endfunction

  function automatic in_item_t mk(longint g, longint w, longint m, longint v, bit l);
    in_item_t it;
    it.gradient_sum  = g[31:0];
    it.weight_in     = w[31:0];
    it.moment_one_in = m[31:0];
    it.moment_two_in = v[31:0];
    it.last_element  = l;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: stall style redrawn at random as stall_phase counts cycles
  // ---------------------------------------------------------------------------
  int stall_phase = 0;
  int stall_style = 0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 512 == 0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: out_stall <= 1'b0;                          // stretch with no stalls
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);   // heavy backpressure
      default: out_stall <= stall_phase[3];
    endcase
  end

  // ---------------------------------------------------------------------------
  // result checker, oldest expectation first
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_upd;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (updates_due.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result item %p", out_item);
      end else begin
        exp_upd = updates_due.pop_front();
        if (out_item.weight_out !== exp_upd.weight_out ||
            out_item.moment_one_out !== exp_upd.moment_one_out ||
            out_item.moment_two_out !== exp_upd.moment_two_out ||
            out_item.last_out !== exp_upd.last_out) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch at result %0d: w %h/%h m1 %h/%h m2 %h/%h last %b/%b",
                     results_seen, exp_upd.weight_out, out_item.weight_out,
                     exp_upd.moment_one_out, out_item.moment_one_out,
                     exp_upd.moment_two_out, out_item.moment_two_out,
                     exp_upd.last_out, out_item.last_out);
        end
      end
    end
  end

  // watchdog: counts cycles in which no item moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired, %0d updates outstanding", updates_due.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  // present one item and hold it until taken; valid stays high afterwards
  task automatic push_item(in_item_t it, bit has_exp, out_item_t exp_typed);
    out_item_t pred;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pred = update_param(it);
    if (mode_r == MODE_SGD) sgd_items++; else adamw_items++;
    if (eps_r == 0) zero_den_items++;
    updates_due.push_back(has_exp ? exp_typed : pred);
    sent++;
  endtask

  // registers only change once the block has drained
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (updates_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, longint val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[COEF_W-1:0];
    case (idx)
      CFG_MODE:  mode_r  = val & 1;
      CFG_LR:    lr_r    = val & (CONE - 1);
      CFG_B1:    b1_r    = val & (CONE - 1);
      CFG_B2:    b2_r    = val & (CONE - 1);
      CFG_EPS:   eps_r   = val & (CONE - 1);
      CFG_DECAY: decay_r = val & (CONE - 1);
      CFG_BATCH: batch_r = val & 16'hffff;
      default:   step_r  = val & 16'hffff;
    endcase
    @(posedge clk);
  endtask

  function automatic longint pick_coef();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return CONE - 1;
      2: return $urandom_range(0, 2000);
      default: return $urandom_range(0, 16777215);
    endcase
  endfunction

  function automatic longint pick_count();
    case ($urandom_range(0, 7))
      0: return 0;                       // treated as one
      1: return 65535;
      2: return $urandom_range(1, 65535);
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  function automatic longint pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return 0;
      3, 4: return longint'($signed($urandom));
      default: return longint'($signed($urandom) >>> $urandom_range(4, 28));
    endcase
  endfunction

  function automatic longint pick_moment_two();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return UVAL_MAX;
      2: return longint'($urandom);
      default: return longint'($urandom >> $urandom_range(4, 31));
    endcase
  endfunction

  // directed table: register writes and items, expected typed in where obvious
  typedef struct {
    bit is_reg;
    logic [CFG_IDX_W-1:0] idx;
    longint val;
    in_item_t it;
    bit has_exp;
    out_item_t exp_upd;
  } row_t;

  row_t plan[$];

  function automatic void add_item(in_item_t it);
    plan.push_back('{0, CFG_MODE, 0, it, 0, '0});
  endfunction

  function automatic void add_known(in_item_t it, out_item_t e);
    plan.push_back('{0, CFG_MODE, 0, it, 1, e});
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    plan.push_back('{1, idx, val, '0, 0, '0});
  endfunction

  initial begin
    int burst, phase_len;
    bit prev_reg;
    shadow_reset();

    // defaults: an all-zero item stays all zero
    add_known(mk(0, 0, 0, 0, 0), '{32'sd0, 32'sd0, 32'd0, 1'b0});
    add_item(mk(VAL_MAX, VAL_MAX, VAL_MAX, UVAL_MAX, 0));
    add_item(mk(VAL_MIN, VAL_MIN, VAL_MIN, 0, 1));
    // no epsilon and no second moment: quotient pinned by the sign
    add_reg(CFG_EPS, 0);
    add_item(mk(0, 0, 64'sd16777216, 0, 0));
    add_item(mk(0, 123456, -64'sd16777216, 0, 0));
    add_known(mk(0, 0, 0, 0, 1), '{32'sd0, 32'sd0, 32'd0, 1'b1});
    // gradient descent, zero batch count and zero step number
    add_reg(CFG_MODE, MODE_SGD);
    add_reg(CFG_BATCH, 0);
    add_reg(CFG_STEP, 0);
    add_known(mk(0, 12345, -777, 4242, 0), '{32'sd12345, -32'sd777, 32'd4242, 1'b0});
    add_item(mk(VAL_MAX, VAL_MIN, VAL_MAX, UVAL_MAX, 0));
    add_item(mk(VAL_MIN, VAL_MAX, VAL_MIN, 0, 1));
    // adamw with every coefficient at an extreme
    add_reg(CFG_MODE, MODE_ADAMW);
    add_reg(CFG_LR, CONE - 1);
    add_reg(CFG_B1, 0);
    add_reg(CFG_B2, CONE - 1);
    add_reg(CFG_EPS, CONE - 1);
    add_reg(CFG_DECAY, CONE - 1);
    add_reg(CFG_BATCH, 65535);
    add_reg(CFG_STEP, 65535);
    add_item(mk(VAL_MAX, VAL_MAX, VAL_MIN, UVAL_MAX, 0));
    add_item(mk(VAL_MIN, VAL_MIN, VAL_MAX, 0, 1));
    add_item(mk(-64'sd5000000, 3000000, 100, 200, 1));

    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_reg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (!prev_reg) wait_drained();
        reg_write(plan[i].idx, plan[i].val);
        prev_reg = 1'b1;
      end else begin
        if (prev_reg) cfg_we <= 1'b0;
        push_item(plan[i].it, plan[i].has_exp, plan[i].exp_upd);
        prev_reg = 1'b0;
      end
    end

    // random phases: new register settings, then a stream of items; a run
    // may span a phase boundary so the beta powers must stay untouched
    while (sent < N_ITEMS) begin
      wait_drained();
      reg_write(CFG_MODE, ($urandom_range(0, 3) == 0) ? MODE_SGD : MODE_ADAMW);
      reg_write(CFG_LR, pick_coef());
      reg_write(CFG_B1, pick_coef());
      reg_write(CFG_B2, pick_coef());
      reg_write(CFG_EPS, ($urandom_range(0, 5) == 0) ? 0 : pick_coef());
      reg_write(CFG_DECAY, pick_coef());
      reg_write(CFG_BATCH, pick_count());
      reg_write(CFG_STEP, pick_count());
      cfg_we <= 1'b0;
      phase_len = $urandom_range(40, 120);
      while (phase_len > 0 && sent < N_ITEMS) begin
        burst = $urandom_range(1, 12);
        while (burst > 0 && phase_len > 0) begin
          push_item(mk(pick_value(), pick_value(), pick_value(), pick_moment_two(),
                       $urandom_range(0, 7) == 0), 0, '0);
          burst--;
          phase_len--;
        end
        // gap between bursts, sometimes none
        if ($urandom_range(0, 2) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 300)) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    while (updates_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d items sent: %0d adamw, %0d gradient descent, %0d with zero epsilon",
             sent, adamw_items, sgd_items, zero_den_items);
    $display("%0d results checked, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
